/* rtl/core/ct97_pkg.sv */
// Package for the 9x7 census transform stream core: window geometry,
// register codes, reset values and the item types of both channels.
// No dependencies.
package ct97_pkg;

  localparam int WIN_ROWS   = 9;
  localparam int WIN_COLS   = 7;
  localparam int HALF_ROWS  = 4;
  localparam int HALF_COLS  = 3;
  localparam int LINES      = 8;
  localparam int LINE_SEL_W = $clog2(LINES);
  localparam int PIX_W      = 8;

  localparam int MAX_WIDTH_DEF  = 2048;
  localparam int MAX_HEIGHT_DEF = 4096;

  localparam int WIDTH_W    = 12;
  localparam int HEIGHT_W   = 13;
  localparam int CFG_DATA_W = 13;
  localparam int CFG_IDX_W  = 1;

  localparam logic [WIDTH_W-1:0]  WIDTH_RST  = 12'd640;
  localparam logic [HEIGHT_W-1:0] HEIGHT_RST = 13'd480;
  localparam logic [WIDTH_W-1:0]  MIN_WIDTH  = 12'd10;
  localparam logic [HEIGHT_W-1:0] MIN_HEIGHT = 13'd8;

  localparam int CENSUS_W  = WIN_ROWS * WIN_COLS;
  localparam int ROW_OUT_W = 12;
  localparam int COL_OUT_W = 11;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_IMAGE_WIDTH  = 1'b0,
    CFG_IMAGE_HEIGHT = 1'b1
  } cfg_index_t;

  typedef logic [PIX_W-1:0] pixel_t;

  typedef struct packed {
    pixel_t pixel_gray;
    logic   frame_start;
  } in_item_t;

  typedef struct packed {
    logic [CENSUS_W-1:0]  census_bits;
    logic [ROW_OUT_W-1:0] center_row;
    logic [COL_OUT_W-1:0] center_col;
  } out_item_t;

endpackage

/* rtl/core/ct97_stream_if.sv */
// Valid/ready stream interface used by both channels of the census core.
// The payload type is a parameter; the core uses the item types of ct97_pkg.
interface ct97_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* rtl/core/census_transform_9x7_stream_core.sv */
// Results pass the line memory read register, then the output register. Throughput: one
// pixel per cycle unless the output stalls; the line memory does one read and one write per
// cycle and the 63 comparators sit between the memory read register and the output.
// Reset (synchronous, rst_n low): counters at zero, pipeline empty, size registers 640 x 480.
// The line memory is not cleared; bytes read before their first write never reach a result.
// Depends on ct97_pkg and ct97_stream_if.
module census_transform_9x7_stream_core #(
  parameter int MAX_WIDTH  = ct97_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = ct97_pkg::MAX_HEIGHT_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  ct97_stream_if.sink                         in_chan,
  ct97_stream_if.source                       out_chan,
  input  logic                                cfg_we,
  input  logic [ct97_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [ct97_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam int WIN_ROWS   = ct97_pkg::WIN_ROWS;
  localparam int WIN_COLS   = ct97_pkg::WIN_COLS;
  localparam int HALF_ROWS  = ct97_pkg::HALF_ROWS;
  localparam int HALF_COLS  = ct97_pkg::HALF_COLS;
  localparam int LINES      = ct97_pkg::LINES;
  localparam int LINE_SEL_W = ct97_pkg::LINE_SEL_W;
  localparam int PIX_W      = ct97_pkg::PIX_W;
  localparam int WIDTH_W    = ct97_pkg::WIDTH_W;
  localparam int HEIGHT_W   = ct97_pkg::HEIGHT_W;
  localparam int CENSUS_W   = ct97_pkg::CENSUS_W;
  localparam int ROW_OUT_W  = ct97_pkg::ROW_OUT_W;
  localparam int COL_OUT_W  = ct97_pkg::COL_OUT_W;

  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int ROW_W  = $clog2(MAX_HEIGHT);
  // compare widths: room for the counter, the register and one more
  localparam int CW_W   = ((COL_W > WIDTH_W) ? COL_W : WIDTH_W) + 1;
  localparam int RW_W   = ((ROW_W > HEIGHT_W) ? ROW_W : HEIGHT_W) + 1;
  localparam int WORD_W = LINES * PIX_W;
  localparam int CENTER_BIT = CENSUS_W - 1 - (HALF_ROWS * WIN_COLS + HALF_COLS);

  // ---------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------
  logic [WIDTH_W-1:0]  image_width_r;
  logic [HEIGHT_W-1:0] image_height_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      image_width_r  <= ct97_pkg::WIDTH_RST;
      image_height_r <= ct97_pkg::HEIGHT_RST;
    end else if (cfg_we) begin
      unique case (ct97_pkg::cfg_index_t'(cfg_index))
        ct97_pkg::CFG_IMAGE_WIDTH:  image_width_r  <= cfg_data[WIDTH_W-1:0];
        ct97_pkg::CFG_IMAGE_HEIGHT: image_height_r <= cfg_data[HEIGHT_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------
  // Stage 0: position counters, emit decision, line memory read
  // ---------------------------------------------------------------
  logic [ROW_W-1:0] row_r, row_nxt, cur_row;
  logic [COL_W-1:0] col_r, col_nxt, cur_col;
  logic [CW_W-1:0]  lim_w;
  logic [RW_W-1:0]  lim_h;
  logic             size_ok, emit_now;
  logic             in_fire, in_ready;

  // stage 1 (memory data valid) registers
  logic               s1_valid_r;
  logic               s1_emit_r;
  ct97_pkg::pixel_t   s1_pix_r;
  logic [ROW_W-1:0]   s1_row_r;
  logic [COL_W-1:0]   s1_col_r;
  logic               s1_fwd_r;
  logic [WORD_W-1:0]  fwd_word_r;
  logic [WORD_W-1:0]  rd_word_r;
  logic               s1_adv;
  logic               mem_we;

  // output register
  logic                out_valid_r;
  ct97_pkg::out_item_t out_data_r;

  assign in_fire = in_chan.valid && in_ready;

  always_comb begin
    cur_row = in_chan.data.frame_start ? '0 : row_r;
    cur_col = in_chan.data.frame_start ? '0 : col_r;

    size_ok = (image_width_r >= ct97_pkg::MIN_WIDTH) &&
              (image_height_r >= ct97_pkg::MIN_HEIGHT) &&
              (CW_W'(image_width_r) <= CW_W'(MAX_WIDTH)) &&
              (RW_W'(image_height_r) <= RW_W'(MAX_HEIGHT));

    // the pixel completes the window centered HALF_ROWS up, HALF_COLS left
    emit_now = size_ok &&
               (RW_W'(cur_row) >= RW_W'(2 * HALF_ROWS)) &&
               (CW_W'(cur_col) >= CW_W'(2 * HALF_COLS)) &&
               (RW_W'(cur_row) < RW_W'(image_height_r)) &&
               (CW_W'(cur_col) < CW_W'(image_width_r));

    lim_w = (CW_W'(image_width_r) < CW_W'(MAX_WIDTH)) ?
            CW_W'(image_width_r) : CW_W'(MAX_WIDTH);
    lim_h = (RW_W'(image_height_r) < RW_W'(MAX_HEIGHT)) ?
            RW_W'(image_height_r) : RW_W'(MAX_HEIGHT);

    // a counter at or past a lowered limit wraps on its next step
    if (CW_W'(cur_col) + CW_W'(1) >= lim_w) begin
      col_nxt = '0;
      row_nxt = (RW_W'(cur_row) + RW_W'(1) >= lim_h) ? '0 : cur_row + ROW_W'(1);
    end else begin
      col_nxt = cur_col + COL_W'(1);
      row_nxt = cur_row;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r <= '0;
      col_r <= '0;
    end else if (in_fire) begin
      row_r <= row_nxt;
      col_r <= col_nxt;
    end
  end

  // ---------------------------------------------------------------
  // Line memory: one word per column, one byte per line slot.
  // Line slot of image row r is r mod 8; the write of a pixel replaces
  // the byte of the row eight above it, which is read in the same pass.
  // ---------------------------------------------------------------
  logic [WORD_W-1:0] line_mem [MAX_WIDTH];
  logic [WORD_W-1:0] wr_word;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      line_mem[s1_col_r] <= wr_word;
    end
    if (in_fire) begin
      rd_word_r <= line_mem[cur_col];
    end
  end

  // ---------------------------------------------------------------
  // Stage 1: build new window column, shift window, compare
  // ---------------------------------------------------------------
  ct97_pkg::pixel_t  win_r   [WIN_ROWS][WIN_COLS];
  ct97_pkg::pixel_t  win_nxt [WIN_ROWS][WIN_COLS];
  ct97_pkg::pixel_t  new_col [WIN_ROWS];
  logic [LINE_SEL_W-1:0] slot;
  logic [LINE_SEL_W-1:0] lane_sel [LINES];
  logic [WORD_W-1:0]     line_word;
  ct97_pkg::pixel_t      center;
  logic [CENSUS_W-1:0]   census;

  always_comb begin
    // same column written last transfer: memory read is stale, take the bypass
    line_word = s1_fwd_r ? fwd_word_r : rd_word_r;
    slot      = s1_row_r[LINE_SEL_W-1:0];

    for (int k = 0; k < LINES; k++) begin
      lane_sel[k] = slot + LINE_SEL_W'(k);
      new_col[k]  = line_word[lane_sel[k]*PIX_W +: PIX_W];
    end
    new_col[WIN_ROWS-1] = s1_pix_r;

    wr_word = line_word;
    wr_word[slot*PIX_W +: PIX_W] = s1_pix_r;

    for (int r = 0; r < WIN_ROWS; r++) begin
      for (int c = 0; c < WIN_COLS - 1; c++) begin
        win_nxt[r][c] = win_r[r][c+1];
      end
      win_nxt[r][WIN_COLS-1] = new_col[r];
    end

    center = win_nxt[HALF_ROWS][HALF_COLS];
    // top-left neighbor lands in the MSB
    for (int r = 0; r < WIN_ROWS; r++) begin
      for (int c = 0; c < WIN_COLS; c++) begin
        census[CENSUS_W-1-(r*WIN_COLS+c)] = (win_nxt[r][c] < center);
      end
    end
  end

  // a non-emitting item never waits on the output register
  assign s1_adv   = s1_valid_r && (!s1_emit_r || !out_valid_r || out_chan.ready);
  assign mem_we   = s1_adv;
  // no transfer is taken while reset is held
  assign in_ready = rst_n && (!s1_valid_r || s1_adv);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= in_fire || (s1_valid_r && !s1_adv);
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_pix_r   <= in_chan.data.pixel_gray;
      s1_row_r   <= cur_row;
      s1_col_r   <= cur_col;
      s1_emit_r  <= emit_now;
      // in_fire with s1 full implies s1 writes at this same edge
      s1_fwd_r   <= s1_valid_r && (s1_col_r == cur_col);
      fwd_word_r <= wr_word;
    end
    if (mem_we) begin
      win_r <= win_nxt;
    end
  end

  // ---------------------------------------------------------------
  // Output register
  // ---------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (mem_we && s1_emit_r) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we && s1_emit_r) begin
      out_data_r.census_bits <= census;
      out_data_r.center_row  <= ROW_OUT_W'(s1_row_r - ROW_W'(HALF_ROWS));
      out_data_r.center_col  <= COL_OUT_W'(s1_col_r - COL_W'(HALF_COLS));
    end
  end

  assign out_chan.valid = out_valid_r;
  assign out_chan.data  = out_data_r;
  assign in_chan.ready  = in_ready;

  // ---------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------
  // a new transfer into a full stage 1 requires that stage to drain now,
  // otherwise the bypass word would be wrong
  a_fill_drains: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && s1_valid_r) |-> mem_we)
    else $error("stage 1 overwritten without writeback");

  // center compares against itself
  a_center_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !out_data_r.census_bits[CENTER_BIT])
    else $error("census center bit set");

  // frame start restarts the position
  a_frame_start: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_chan.data.frame_start) |=> (s1_row_r == '0 && s1_col_r == '0))
    else $error("frame start did not restart counters");

endmodule
